### hdl/mip_downsample_box_2x2_defines.svh
// Assertion macros for the mip downsample block.
`ifndef MIP_DOWNSAMPLE_BOX_2X2_DEFINES_SVH
`define MIP_DOWNSAMPLE_BOX_2X2_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MDB_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("mdb assertion failed");
// next-cycle implication
`define MDB_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("mdb assertion failed");
`else
`define MDB_ASSERT_NOW(lbl, clk, rst_n, pre, post)
`define MDB_ASSERT_NXT(lbl, clk, rst_n, pre, post)
`endif

`endif

### hdl/mdb_pkg.sv
package mdb_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int HEIGHT_LIMIT = 2048;
    localparam int HALF_WIDTH   = MAX_WIDTH / 2;

    localparam int SIZE_W    = 12;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(HEIGHT_LIMIT);
    localparam int OC_W      = $clog2(HALF_WIDTH);
    localparam int OR_W      = $clog2(HEIGHT_LIMIT / 2);
    localparam int CH_W      = 8;
    localparam int LANE_W    = CH_W + 1;
    localparam int LANES     = 4;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_WIDTH  = 1'b0,
        CFG_SOURCE_HEIGHT = 1'b1
    } t_cfg_idx;

    // four channel lanes, 9 bits each so a pair sum fits
    typedef logic [LANES-1:0][LANE_W-1:0] t_pix;

    typedef struct packed {
        logic            w_one;
        logic            pair_load;
        logic            row_store;
        logic            row_fetch;
        logic            emit;
        logic            last;
        logic [OC_W-1:0] oc;
    } t_scan_ctl;

    // zero reads as one, oversize reads as the limit
    function automatic logic [SIZE_W-1:0] size_clamp(input logic [SIZE_W-1:0] v,
                                                     input int limit);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (int'(v) > limit) begin
            r = SIZE_W'(limit);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

### hdl/mdb_scan.sv
module mdb_scan
    import mdb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [SIZE_W-1:0]    i_cfg_data,
    input  logic                 i_adv,
    output t_scan_ctl            o_ctl
);

    logic [COL_W-1:0] r_w_last;
    logic [ROW_W-1:0] r_h_last;
    logic [OC_W-1:0]  r_ow_last;
    logic [OR_W-1:0]  r_oh_last;
    logic             r_w_one;
    logic             r_h_one;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;

    logic [SIZE_W-1:0] w_size;
    logic [SIZE_W-1:0] h_size;
    logic              have_h;
    logic [OC_W-1:0]   oc;
    logic [OR_W-1:0]   orow;

    assign w_size = size_clamp(i_cfg_data, MAX_WIDTH);
    assign h_size = size_clamp(i_cfg_data, HEIGHT_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last  <= '0;
            r_h_last  <= '0;
            r_ow_last <= '0;
            r_oh_last <= '0;
            r_w_one   <= 1'b1;
            r_h_one   <= 1'b1;
            r_col     <= '0;
            r_row     <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SOURCE_WIDTH: begin
                    r_w_last  <= COL_W'(w_size - SIZE_W'(1));
                    r_w_one   <= (w_size == SIZE_W'(1));
                    r_ow_last <= (w_size == SIZE_W'(1)) ? '0
                                 : OC_W'((w_size >> 1) - SIZE_W'(1));
                end
                CFG_SOURCE_HEIGHT: begin
                    r_h_last  <= ROW_W'(h_size - SIZE_W'(1));
                    r_h_one   <= (h_size == SIZE_W'(1));
                    r_oh_last <= (h_size == SIZE_W'(1)) ? '0
                                 : OR_W'((h_size >> 1) - SIZE_W'(1));
                end
                default: begin
                end
            endcase
            r_col <= '0;
            r_row <= '0;
        end else if (i_adv) begin
            if (r_col == r_w_last) begin
                r_col <= '0;
                r_row <= (r_row == r_h_last) ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // odd column closes a pair; an odd dropped last column is always even
    assign have_h = r_w_one || r_col[0];
    assign oc     = r_w_one ? '0 : OC_W'(r_col >> 1);
    assign orow   = OR_W'(r_row >> 1);

    always_comb begin
        o_ctl           = '0;
        o_ctl.w_one     = r_w_one;
        o_ctl.pair_load = !r_w_one && !r_col[0];
        o_ctl.row_store = have_h && !r_h_one && !r_row[0];
        o_ctl.row_fetch = have_h && !r_h_one && r_row[0];
        o_ctl.emit      = have_h && (r_h_one || r_row[0]);
        o_ctl.last      = (oc == r_ow_last) && (r_h_one || orow == r_oh_last);
        o_ctl.oc        = oc;
    end

endmodule

### hdl/mip_downsample_box_2x2.sv
// 2x2 box-filter mip reduction, RGBA8, raster order in and out.
// Input channel: i_in_valid / o_in_stall with one pixel per item; an item
// is taken on a clock edge with valid high and stall low.
// Output channel: o_out_valid / i_out_stall; one result item per 2x2 block,
// channel = floor(sum / 4), o_last_of_level marks the final output pixel.
// Configuration: i_cfg_we writes source width (index 0) or height (index 1);
// each write restarts the level. Write only while the block is idle.
// Throughput: one pixel per clock while o_in_stall is low. The sums for
// the pixel that completes a block are registered in the second stage, then the output register.
// The even source row leaves its horizontal pair sums in a 1024 x 36 row
// memory (registered read); the odd row reads them back and the sum is
// finished in the following stage. No write and read of one entry share a
// cycle, so no forwarding is needed.
// Reset: size 1 x 1, counters at zero, pipeline empty; the row memory is
// not cleared, since every level writes it before reading it.
// When the receiver stalls, the output register holds and one more result
// waits in the second stage; the input then stalls whenever that stage
// holds a result that cannot move.
module mip_downsample_box_2x2
    import mdb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [SIZE_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [CH_W-1:0]      i_red_in,
    input  logic [CH_W-1:0]      i_green_in,
    input  logic [CH_W-1:0]      i_blue_in,
    input  logic [CH_W-1:0]      i_alpha_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [CH_W-1:0]      o_red_out,
    output logic [CH_W-1:0]      o_green_out,
    output logic [CH_W-1:0]      o_blue_out,
    output logic [CH_W-1:0]      o_alpha_out,
    output logic                 o_last_of_level
);

`include "mip_downsample_box_2x2_defines.svh"

    t_scan_ctl ctl;
    logic      in_acc;
    logic      s2_adv;

    t_pix pix;
    t_pix hsum;
    t_pix top;
    t_pix r_hpair;
    t_pix r_rd;
    t_pix r_s2_hsum;
    logic r_s2_valid;
    logic r_s2_fetch;
    logic r_s2_last;

    logic [LANES-1:0][LANE_W:0] quad;

    t_pix r_row_mem [HALF_WIDTH];

    mdb_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_adv      (in_acc),
        .o_ctl      (ctl)
    );

    assign s2_adv     = r_s2_valid && (!o_out_valid || !i_out_stall);
    assign o_in_stall = r_s2_valid && !s2_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign pix[0] = {1'b0, i_red_in};
    assign pix[1] = {1'b0, i_green_in};
    assign pix[2] = {1'b0, i_blue_in};
    assign pix[3] = {1'b0, i_alpha_in};

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            // a width of one counts the edge pixel twice
            hsum[l] = ctl.w_one ? {pix[l][LANE_W-2:0], 1'b0} : r_hpair[l] + pix[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hpair <= '0;
        end else if (in_acc && ctl.pair_load) begin
            r_hpair <= pix;
        end
    end

    // row of pair sums
    always_ff @(posedge i_clk) begin
        if (in_acc && ctl.row_store) begin
            r_row_mem[ctl.oc] <= hsum;
        end
        if (in_acc && ctl.row_fetch) begin
            r_rd <= r_row_mem[ctl.oc];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (in_acc && ctl.emit) begin
            r_s2_valid <= 1'b1;
        end else if (s2_adv) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && ctl.emit) begin
            r_s2_hsum  <= hsum;
            r_s2_fetch <= ctl.row_fetch;
            r_s2_last  <= ctl.last;
        end
    end

    // a height of one uses the same row as top and bottom
    assign top = r_s2_fetch ? r_rd : r_s2_hsum;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            quad[l] = {1'b0, top[l]} + {1'b0, r_s2_hsum[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (s2_adv) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv) begin
            o_red_out       <= quad[0][LANE_W:2];
            o_green_out     <= quad[1][LANE_W:2];
            o_blue_out      <= quad[2][LANE_W:2];
            o_alpha_out     <= quad[3][LANE_W:2];
            o_last_of_level <= r_s2_last;
        end
    end

    `MDB_ASSERT_NOW(a_one_mem_op, i_clk, i_rst_n, 1'b1,
        $onehot0({ctl.pair_load, ctl.row_store, ctl.row_fetch}))
    `MDB_ASSERT_NXT(a_s2_hold, i_clk, i_rst_n, r_s2_valid && !s2_adv,
        r_s2_valid && $stable(r_s2_hsum) && $stable(r_s2_last))
    `MDB_ASSERT_NXT(a_rd_hold, i_clk, i_rst_n, r_s2_valid && r_s2_fetch && !s2_adv,
        $stable(r_rd))

endmodule
